// ===== design/gbn_pkg.sv =====
// Package for the go-back-N sender: event codes, result flag group,
// configuration indexes, reset values and fixed field widths. No dependencies.
package gbn_pkg;

    localparam int SIZE_W    = 10;  // segment size and segment limit width
    localparam int WIN_W     = 10;  // window and in-flight counter width
    localparam int DUP_W     = 2;   // duplicate ACK counter width
    localparam int CFG_IDX_W = 2;   // configuration register index width
    localparam int OUT_USER_W = 3;  // result flags carried in tuser

    // Bit positions of the result flags in the output tuser.
    localparam int USER_SEND_VALID    = 0;
    localparam int USER_WENT_BACK     = 1;
    localparam int USER_TRANSFER_DONE = 2;

    localparam logic [DUP_W-1:0]  DUP_LIMIT      = 2'd3;
    localparam logic [WIN_W-1:0]  INFLIGHT_MAX   = '1;
    localparam logic [WIN_W-1:0]  RST_WINDOW     = 10'd4;
    localparam logic [SIZE_W-1:0] RST_SEG_LIMIT  = 10'd994;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW       = 2'd0,
        CFG_TRANSFER_LEN = 2'd1,
        CFG_SEG_LIMIT    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic send_valid;
        logic seg_final;
        logic went_back;
        logic transfer_done;
    } t_flags;

endpackage

// ===== design/gbn_cfg_regs.sv =====
// Configuration registers of the go-back-N sender (window, length, max payload).
// Depends on gbn_pkg for register indexes and reset values.
module gbn_cfg_regs
    import gbn_pkg::*;
#(
    parameter int OFFSET_WIDTH = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr,
    input  logic [CFG_IDX_W-1:0]    i_index,
    input  logic [OFFSET_WIDTH-1:0] i_data,
    output logic [WIN_W-1:0]        o_window,
    output logic [OFFSET_WIDTH-1:0] o_length,
    output logic [SIZE_W-1:0]       o_seg_limit
);

    logic [WIN_W-1:0]        r_window;
    logic [OFFSET_WIDTH-1:0] r_length;
    logic [SIZE_W-1:0]       r_seg_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= RST_WINDOW;
            r_length    <= '0;
            r_seg_limit <= RST_SEG_LIMIT;
        end else if (i_wr) begin
            unique case (t_cfg_index'(i_index))
                CFG_WINDOW:       r_window    <= i_data[WIN_W-1:0];
                CFG_TRANSFER_LEN: r_length    <= i_data;
                CFG_SEG_LIMIT:    r_seg_limit <= i_data[SIZE_W-1:0];
                default: ;  // Writes to unused indexes are dropped.
            endcase
        end
    end

    assign o_window    = r_window;
    assign o_length    = r_length;
    assign o_seg_limit = r_seg_limit;

endmodule

// ===== design/gbn_in_stage.sv =====
// Input register of the go-back-N sender: holds one event until the core takes it.
// Depends on gbn_pkg for the event code type.
module gbn_in_stage
    import gbn_pkg::*;
#(
    parameter int OFFSET_WIDTH = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_opcode                 i_op,
    input  logic [OFFSET_WIDTH-1:0] i_ack,
    input  logic                    i_advance,
    output logic                    o_ready,
    output logic                    o_valid,
    output t_opcode                 o_op,
    output logic [OFFSET_WIDTH-1:0] o_ack
);

    logic                    r_valid;
    t_opcode                 r_op;
    logic [OFFSET_WIDTH-1:0] r_ack;

    // The register frees up in the same cycle that the core consumes it.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op  <= i_op;
            r_ack <= i_ack;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_ack   = r_ack;

endmodule

// ===== design/gbn_core.sv =====
// Sender state and per-event update of the go-back-N sender.
// Depends on gbn_pkg for event codes, widths and the result flag struct.
module gbn_core
    import gbn_pkg::*;
#(
    parameter int OFFSET_WIDTH = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  t_opcode                 i_op,
    input  logic [OFFSET_WIDTH-1:0] i_ack,
    input  logic [WIN_W-1:0]        i_window,
    input  logic [OFFSET_WIDTH-1:0] i_length,
    input  logic [SIZE_W-1:0]       i_seg_limit,
    output t_flags                  o_flags,
    output logic [OFFSET_WIDTH-1:0] o_seg_offset,
    output logic [SIZE_W-1:0]       o_seg_size
);

    localparam int PAD_W = OFFSET_WIDTH - SIZE_W;

    logic [OFFSET_WIDTH-1:0] r_next_offset, n_next_offset;
    logic [OFFSET_WIDTH-1:0] r_acked_offset, n_acked_offset;
    logic [WIN_W-1:0]        r_in_flight, n_in_flight;
    logic [DUP_W-1:0]        r_dup_count, n_dup_count;

    logic [SIZE_W-1:0]       mp;
    logic [OFFSET_WIDTH-1:0] remaining;
    logic [SIZE_W-1:0]       size;
    logic [OFFSET_WIDTH-1:0] advanced;
    logic [DUP_W-1:0]        dup_inc;
    logic                    can_send;

    always_comb begin
        mp        = (i_seg_limit == '0) ? SIZE_W'(1) : i_seg_limit;
        remaining = i_length - r_next_offset;
        size      = (remaining < {{PAD_W{1'b0}}, mp}) ? remaining[SIZE_W-1:0] : mp;
        advanced  = r_next_offset + {{PAD_W{1'b0}}, size};
        can_send  = (r_in_flight < i_window) && (r_next_offset < i_length);
        dup_inc   = r_dup_count + DUP_W'(1);

        n_next_offset  = r_next_offset;
        n_acked_offset = r_acked_offset;
        n_in_flight    = r_in_flight;
        n_dup_count    = r_dup_count;
        o_flags        = '0;
        o_seg_offset   = '0;
        o_seg_size     = '0;

        case (i_op)
            OP_SEND: begin
                if (can_send) begin
                    o_flags.send_valid = 1'b1;
                    o_flags.seg_final  = (advanced == i_length);
                    o_seg_offset       = r_next_offset;
                    o_seg_size         = size;
                    n_next_offset      = advanced;
                    if (r_in_flight != INFLIGHT_MAX) begin
                        n_in_flight = r_in_flight + WIN_W'(1);
                    end
                end
            end
            OP_ACK: begin
                if (i_ack == r_acked_offset) begin
                    n_dup_count = dup_inc;
                    if (dup_inc == DUP_LIMIT) begin
                        n_next_offset     = r_acked_offset;
                        n_in_flight       = '0;
                        n_dup_count       = '0;
                        o_flags.went_back = 1'b1;
                    end
                end else begin
                    n_acked_offset = i_ack;
                    n_dup_count    = '0;
                    if (r_in_flight != '0) begin
                        n_in_flight = r_in_flight - WIN_W'(1);
                    end
                end
            end
            OP_TIMEOUT: begin
                n_next_offset     = r_acked_offset;
                n_in_flight       = '0;
                n_dup_count       = '0;
                o_flags.went_back = 1'b1;
            end
            default: ;  // The unused code leaves the state alone.
        endcase

        o_flags.transfer_done = (n_acked_offset == i_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_offset  <= '0;
            r_acked_offset <= '0;
            r_in_flight    <= '0;
            r_dup_count    <= '0;
        end else if (i_fire) begin
            r_next_offset  <= n_next_offset;
            r_acked_offset <= n_acked_offset;
            r_in_flight    <= n_in_flight;
            r_dup_count    <= n_dup_count;
        end
    end

endmodule

// ===== design/gbn_out_stage.sv =====
// Result register of the go-back-N sender; holds a result until it is taken.
// Depends on gbn_pkg for the result flag struct and field widths.
module gbn_out_stage
    import gbn_pkg::*;
#(
    parameter int OFFSET_WIDTH = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  t_flags                  i_flags,
    input  logic [OFFSET_WIDTH-1:0] i_seg_offset,
    input  logic [SIZE_W-1:0]       i_seg_size,
    input  logic                    i_ready,
    output logic                    o_free,
    output logic                    o_valid,
    output t_flags                  o_flags,
    output logic [OFFSET_WIDTH-1:0] o_seg_offset,
    output logic [SIZE_W-1:0]       o_seg_size
);

    logic                    r_valid;
    t_flags                  r_flags;
    logic [OFFSET_WIDTH-1:0] r_seg_offset;
    logic [SIZE_W-1:0]       r_seg_size;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags      <= i_flags;
            r_seg_offset <= i_seg_offset;
            r_seg_size   <= i_seg_size;
        end
    end

    assign o_valid      = r_valid;
    assign o_flags      = r_flags;
    assign o_seg_offset = r_seg_offset;
    assign o_seg_size   = r_seg_size;

endmodule

// ===== design/go_back_n_sender.sv =====
// Top level of the go-back-N sender.
// Depends on gbn_pkg, gbn_cfg_regs, gbn_in_stage, gbn_core and gbn_out_stage.
//
// The sender takes one event per request on the slave stream (tuser holds the event
// code: send slot, ACK or timeout; tdata holds the cumulative ACK offset) and returns
// exactly one result per event on the master stream. A send slot produces a segment
// descriptor when fewer than window_packets segments are outstanding and bytes remain;
// the third duplicate ACK or a timeout rewinds the send point to the last ACK. Events
// are accepted back to back, one per clock cycle, as long as results are taken; a
// result is presented once its event has passed from the input register through
// the state update into the result register. The sustained rate of one event per
// cycle is set by the loop through the sender state registers. The result register
// frees itself in the cycle it is taken, so a stalled output only stops new events
// once both registers hold data. The configuration port is always ready and needs
// no clearing pass after reset; write it only while no event is pending. Indexes:
// 0 window_packets, 1 transfer_length, 2 largest segment payload in bytes.
module go_back_n_sender
    import gbn_pkg::*;
#(
    parameter int OFFSET_WIDTH = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [OFFSET_WIDTH-1:0] i_cfg_data,

    // Event stream.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: ack_offset [OFFSET_WIDTH-1:0], zero padding above
    input  logic [((OFFSET_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode [1:0]
    input  logic [1:0] s_axis_tuser,

    // Result stream.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: seg_offset [OFFSET_WIDTH-1:0], seg_size [OFFSET_WIDTH+9:OFFSET_WIDTH],
    //        zero padding above
    output logic [((OFFSET_WIDTH+SIZE_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: send_valid [0], went_back [1], transfer_done [2]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // tlast: seg_final
    output logic m_axis_tlast
);

    localparam int OUT_DATA_W = ((OFFSET_WIDTH + SIZE_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OFFSET_WIDTH - SIZE_W;

    logic [WIN_W-1:0]        window;
    logic [OFFSET_WIDTH-1:0] length;
    logic [SIZE_W-1:0]       seg_limit;

    logic                    ev_valid;
    t_opcode                 ev_op;
    logic [OFFSET_WIDTH-1:0] ev_ack;

    t_flags                  core_flags;
    logic [OFFSET_WIDTH-1:0] core_offset;
    logic [SIZE_W-1:0]       core_size;

    logic                    out_free;
    t_flags                  res_flags;
    logic [OFFSET_WIDTH-1:0] res_offset;
    logic [SIZE_W-1:0]       res_size;

    // The held event moves into the result register whenever that register is
    // empty or being emptied in the same cycle.
    logic advance;
    assign advance = ev_valid && out_free;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    gbn_cfg_regs #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (i_cfg_valid),
        .i_index     (i_cfg_index),
        .i_data      (i_cfg_data),
        .o_window    (window),
        .o_length    (length),
        .o_seg_limit (seg_limit)
    );

    gbn_in_stage #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_op      (t_opcode'(s_axis_tuser)),
        .i_ack     (s_axis_tdata[OFFSET_WIDTH-1:0]),
        .i_advance (advance),
        .o_ready   (s_axis_tready),
        .o_valid   (ev_valid),
        .o_op      (ev_op),
        .o_ack     (ev_ack)
    );

    gbn_core #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_op         (ev_op),
        .i_ack        (ev_ack),
        .i_window     (window),
        .i_length     (length),
        .i_seg_limit  (seg_limit),
        .o_flags      (core_flags),
        .o_seg_offset (core_offset),
        .o_seg_size   (core_size)
    );

    gbn_out_stage #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance),
        .i_flags      (core_flags),
        .i_seg_offset (core_offset),
        .i_seg_size   (core_size),
        .i_ready      (m_axis_tready),
        .o_free       (out_free),
        .o_valid      (m_axis_tvalid),
        .o_flags      (res_flags),
        .o_seg_offset (res_offset),
        .o_seg_size   (res_size)
    );

    // Pack the result fields onto the master stream.
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_size, res_offset};
    assign m_axis_tlast = res_flags.seg_final;

    always_comb begin
        m_axis_tuser                     = '0;
        m_axis_tuser[USER_SEND_VALID]    = res_flags.send_valid;
        m_axis_tuser[USER_WENT_BACK]     = res_flags.went_back;
        m_axis_tuser[USER_TRANSFER_DONE] = res_flags.transfer_done;
    end

endmodule

// ===== design/gbn_checker.sv =====
// Port-level checks for the go-back-N sender, bound to the top level.
// Depends on gbn_pkg for field widths and tuser bit positions.
module gbn_checker
    import gbn_pkg::*;
#(
    parameter int OFFSET_WIDTH = 28
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((OFFSET_WIDTH+SIZE_W+7)/8)*8-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic m_axis_tlast
);

    // No result is shown in the cycle after a reset edge.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A result without a segment carries no descriptor.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[USER_SEND_VALID]) |->
        (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("descriptor fields set without a segment");

    // An emitted segment always carries at least one byte.
    a_nonempty_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_SEND_VALID]) |->
        (m_axis_tdata[OFFSET_WIDTH +: SIZE_W] != '0))
        else $error("segment of zero bytes");

    // Sending and rewinding never come from the same event.
    a_send_or_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[USER_SEND_VALID] && m_axis_tuser[USER_WENT_BACK]))
        else $error("segment and rewind in one result");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind go_back_n_sender gbn_checker #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_gbn_checker (.*);

// ===== tb/go_back_n_sender_test.sv =====
// Self-checking testbench for the go-back-N sender: event stream in, one
// segment result per event out, plus configuration writes. Depends on gbn_pkg.
`timescale 1ns / 100ps

module go_back_n_sender_test;
    import gbn_pkg::*;

    localparam int OFS_W    = 28;
    localparam int S_DATA_W = ((OFS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OFS_W + SIZE_W + 7) / 8) * 8;

    // The event code that the block does not define; it must leave the state alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_PHASES    = 9;
    localparam int EVENTS_PER_PHASE = 112;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [1:0]       op;
        logic [OFS_W-1:0] ack;
    } t_event;

    typedef struct packed {
        logic              send_valid;
        logic [OFS_W-1:0]  seg_offset;
        logic [SIZE_W-1:0] seg_size;
        logic              seg_final;
        logic              went_back;
        logic              transfer_done;
    } t_segment_result;

    typedef struct packed {
        logic [OFS_W-1:0] next_ofs;
        logic [OFS_W-1:0] acked;
        logic [WIN_W-1:0] in_flight;
        logic [DUP_W-1:0] dups;
    } t_sender_state;

    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic [OFS_W-1:0]  length;
        logic [SIZE_W-1:0] max_pay;
    } t_settings;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [OFS_W-1:0]     i_cfg_data  = '0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    go_back_n_sender #(
        .OFFSET_WIDTH(OFS_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copies of the register file and of the sender state. The settings
    // follow each accepted configuration request; the state follows each
    // accepted event request.
    t_settings     cur_cfg  = '{window: RST_WINDOW, length: '0, max_pay: RST_SEG_LIMIT};
    t_sender_state pred_st  = '0;
    t_sender_state plan_st;

    t_event          pending_events[$];
    t_segment_result segments_due[$];

    int sender_idle_pct   = 33;
    int receiver_idle_pct = 87;

    int unsigned n_queued   = 0;
    int unsigned n_results  = 0;
    int unsigned n_segments = 0;
    int unsigned n_rewinds  = 0;
    int unsigned n_done     = 0;
    int unsigned n_settings = 0;
    int unsigned mismatches = 0;

    t_event          drv_ev;
    t_segment_result drv_seg;
    t_segment_result mon_due;
    t_segment_result mon_got;

    // Both a timeout and the third duplicate ACK pull the send point back to the
    // last recorded ACK and forget everything that was in flight.
    function automatic void rewind_to_ack(inout t_sender_state st);
        st.next_ofs  = st.acked;
        st.in_flight = '0;
        st.dups      = '0;
    endfunction

    // Computes the result of one event and advances the state it is given.
    function automatic t_segment_result predict_event(inout t_sender_state st,
                                                      input t_settings cfg,
                                                      input t_event ev);
        t_segment_result  r;
        logic [SIZE_W-1:0] pay;
        logic [OFS_W-1:0]  remaining;
        logic [OFS_W-1:0]  seg_len;
        r = '0;
        case (ev.op)
            OP_SEND: begin
                if (st.in_flight < cfg.window && st.next_ofs < cfg.length) begin
                    // A zero maximum payload still moves one byte per segment.
                    pay       = (cfg.max_pay == '0) ? SIZE_W'(1) : cfg.max_pay;
                    remaining = cfg.length - st.next_ofs;
                    seg_len   = (remaining < OFS_W'(pay)) ? remaining : OFS_W'(pay);
                    r.send_valid = 1'b1;
                    r.seg_offset = st.next_ofs;
                    r.seg_size   = seg_len[SIZE_W-1:0];
                    st.next_ofs  = st.next_ofs + seg_len;
                    r.seg_final  = (st.next_ofs == cfg.length);
                    if (st.in_flight != INFLIGHT_MAX)
                        st.in_flight = st.in_flight + WIN_W'(1);
                end
            end
            OP_ACK: begin
                if (ev.ack == st.acked) begin
                    st.dups = st.dups + DUP_W'(1);
                    if (st.dups == DUP_LIMIT) begin
                        rewind_to_ack(st);
                        r.went_back = 1'b1;
                    end
                end else begin
                    // Any other value is taken as the new cumulative ACK, even
                    // one behind the old ACK or beyond the end of the transfer.
                    st.acked = ev.ack;
                    st.dups  = '0;
                    if (st.in_flight != '0)
                        st.in_flight = st.in_flight - WIN_W'(1);
                end
            end
            OP_TIMEOUT: begin
                rewind_to_ack(st);
                r.went_back = 1'b1;
            end
            default: ;
        endcase
        r.transfer_done = (st.acked == cfg.length);
        return r;
    endfunction

    // Picks one random event that mostly makes protocol sense for the given
    // state: send slots, ACKs inside the outstanding range and duplicates, with
    // a little noise (timeouts, arbitrary ACKs and the unused code) mixed in.
    function automatic t_event plan_event(t_sender_state st, t_settings cfg);
        t_event      ev;
        int unsigned pick;
        pick   = $urandom_range(99);
        ev.ack = OFS_W'($urandom);
        if (pick < 42) begin
            ev.op = OP_SEND;
        end else if (pick < 80) begin
            ev.op = OP_ACK;
            if (st.acked > cfg.length)
                ev.ack = OFS_W'($urandom_range(cfg.length, 0));
            else if (st.next_ofs > st.acked && $urandom_range(3) == 0)
                ev.ack = st.next_ofs;
            else if (st.next_ofs > st.acked)
                ev.ack = OFS_W'($urandom_range(st.next_ofs, st.acked + 1));
            else
                ev.ack = st.acked;
        end else if (pick < 88) begin
            ev.op  = OP_ACK;
            ev.ack = st.acked;
        end else if (pick < 91) begin
            ev.op  = OP_ACK;
            ev.ack = cfg.length;
        end else if (pick < 95) begin
            ev.op = OP_TIMEOUT;
        end else if (pick < 98) begin
            ev.op = OP_ACK;
        end else begin
            ev.op = OP_UNUSED;
        end
        return ev;
    endfunction

    task automatic queue_event(input logic [1:0] op, input logic [OFS_W-1:0] ack);
        pending_events.push_back('{op: op, ack: ack});
        n_queued++;
    endtask

    // Waits until every queued event has produced its result, then lets the
    // two-stage pipeline settle before anything else happens.
    task automatic wait_for_results();
        while (n_results < n_queued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One request on the configuration channel. The shadow register changes at
    // the edge where the request is taken.
    task automatic write_reg(input t_cfg_index idx, input logic [OFS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW:       cur_cfg.window  = value[WIN_W-1:0];
            CFG_TRANSFER_LEN: cur_cfg.length  = value;
            CFG_SEG_LIMIT:    cur_cfg.max_pay = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [WIN_W-1:0] window,
                                  input logic [OFS_W-1:0] length,
                                  input logic [SIZE_W-1:0] max_pay);
        write_reg(CFG_WINDOW, OFS_W'(window));
        write_reg(CFG_TRANSFER_LEN, length);
        write_reg(CFG_SEG_LIMIT, OFS_W'(max_pay));
        n_settings++;
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Event driver. A new request is presented only when the slot is free or
    // its request is being taken at this edge, so tvalid never drops while a
    // request is waiting. The expected result is worked out when the request
    // is taken, from the state as the block sees it at that moment.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                drv_ev.op  = s_axis_tuser;
                drv_ev.ack = s_axis_tdata[OFS_W-1:0];
                drv_seg    = predict_event(pred_st, cur_cfg, drv_ev);
                segments_due.push_back(drv_seg);
                n_segments += drv_seg.send_valid;
                n_rewinds  += drv_seg.went_back;
                n_done     += drv_seg.transfer_done;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    drv_ev = pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= drv_ev.op;
                    s_axis_tdata  <= S_DATA_W'(drv_ev.ack);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every taken result is matched against the oldest
    // expectation; tready is toggled at random to stall the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                mon_got.send_valid    = m_axis_tuser[USER_SEND_VALID];
                mon_got.seg_offset    = m_axis_tdata[OFS_W-1:0];
                mon_got.seg_size      = m_axis_tdata[OFS_W+SIZE_W-1:OFS_W];
                mon_got.seg_final     = m_axis_tlast;
                mon_got.went_back     = m_axis_tuser[USER_WENT_BACK];
                mon_got.transfer_done = m_axis_tuser[USER_TRANSFER_DONE];
                if (segments_due.size() == 0) begin
                    note_mismatch("result arrived with no event waiting for it");
                end else begin
                    mon_due = segments_due.pop_front();
                    if (mon_got !== mon_due)
                        note_mismatch($sformatf({"result %0d expected ",
                            "valid=%0b ofs=%0d size=%0d last=%0b back=%0b done=%0b, got ",
                            "valid=%0b ofs=%0d size=%0d last=%0b back=%0b done=%0b"},
                            n_results,
                            mon_due.send_valid, mon_due.seg_offset, mon_due.seg_size,
                            mon_due.seg_final, mon_due.went_back, mon_due.transfer_done,
                            mon_got.send_valid, mon_got.seg_offset, mon_got.seg_size,
                            mon_got.seg_final, mon_got.went_back, mon_got.transfer_done));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Sequence of the run: reset, a directed part, then random phases under
    // changing register settings and idling patterns.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the transfer length is zero, so nothing may be sent.
        // An ACK of zero right after reset already counts as a duplicate, so
        // the third one rewinds. The unused code must touch nothing.
        queue_event(OP_SEND, '0);
        queue_event(OP_ACK, '0);
        queue_event(OP_ACK, '0);
        queue_event(OP_ACK, '0);
        queue_event(OP_UNUSED, '1);
        queue_event(OP_TIMEOUT, '1);
        wait_for_results();

        // A window of two with full-size segments: the third send slot is
        // blocked by the window, a new ACK reopens it, the last segment is
        // short and final, three duplicates rewind, and ACKs at, beyond and
        // behind the transfer length are all taken as given.
        apply_settings(10'd2, 28'd2500, 10'd1023);
        queue_event(OP_SEND, '0);
        queue_event(OP_SEND, '0);
        queue_event(OP_SEND, '0);
        queue_event(OP_ACK, 28'd1023);
        queue_event(OP_SEND, '0);
        queue_event(OP_SEND, '0);
        queue_event(OP_ACK, 28'd1023);
        queue_event(OP_ACK, 28'd1023);
        queue_event(OP_ACK, 28'd1023);
        queue_event(OP_SEND, '0);
        queue_event(OP_ACK, 28'd2500);
        queue_event(OP_ACK, '1);
        queue_event(OP_ACK, 28'd100);
        queue_event(OP_TIMEOUT, '0);
        wait_for_results();

        // A zero window never sends; a zero maximum payload sends single bytes.
        apply_settings('0, '1, '0);
        queue_event(OP_SEND, '0);
        wait_for_results();
        write_reg(CFG_WINDOW, OFS_W'(10'd1023));
        queue_event(OP_SEND, '0);
        queue_event(OP_SEND, '0);
        wait_for_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 3) begin
                sender_idle_pct   = 33;
                receiver_idle_pct = 87;
            end else if (p < 6) begin
                sender_idle_pct   = 87;
                receiver_idle_pct = 33;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (p)
                0: apply_settings(10'd4, 28'd20000, 10'd994);
                1: apply_settings(10'd1, 28'd3000, 10'd1023);
                2: apply_settings(10'd1023, 28'hFFFFFFF, 10'd1023);
                3: apply_settings(10'd8, 28'd700, 10'd0);
                4: apply_settings(10'd0, 28'd5000, 10'd200);
                6: apply_settings(10'd2, 28'd1, 10'd1);
                default: apply_settings(WIN_W'($urandom_range(16, 1)),
                                        OFS_W'($urandom_range(40000, 1)),
                                        SIZE_W'($urandom_range(1023, 1)));
            endcase
            // The block is idle here, so the running prediction is also the
            // state from which this phase's stimulus is planned.
            plan_st = pred_st;
            for (int i = 0; i < EVENTS_PER_PHASE; i++) begin
                drv_ev = plan_event(plan_st, cur_cfg);
                void'(predict_event(plan_st, cur_cfg, drv_ev));
                queue_event(drv_ev.op, drv_ev.ack);
            end
            wait_for_results();
        end

        $display("Ran %0d events under %0d register settings and three idling patterns.",
                 n_queued, n_settings);
        $display("They produced %0d segments, %0d rewinds and %0d results with the transfer done.",
                 n_segments, n_rewinds, n_done);
        if (mismatches == 0 && segments_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     segments_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run of the stimulus above.
    initial begin
        #1000000;
        $display("Timeout: %0d of %0d results arrived", n_results, n_queued);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
